### design/crt_pkg.sv
package crt_pkg;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOSOL = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    // divider operation codes
    typedef enum logic [1:0] {
        t_div_rem = 2'd0,
        t_div_quo = 2'd1
    } t_div_op;

endpackage

### design/crt_stream_if.sv
interface crt_in_if #(
    parameter int WIDTH = 32
) ();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] residue;
    logic [WIDTH-1:0] modulus;
    logic             last;

    modport source (output valid, residue, modulus, last, input ready);
    modport sink   (input valid, residue, modulus, last, output ready);
endinterface

interface crt_out_if ();
    logic        valid;
    logic        ready;
    logic [62:0] result_residue;
    logic [62:0] result_modulus;
    logic [1:0]  status;

    modport source (output valid, result_residue, result_modulus, status, input ready);
    modport sink   (input valid, result_residue, result_modulus, status, output ready);
endinterface

### design/crt_divider.sv
// Restoring divider, one quotient bit per cycle over 64-bit operands.
module crt_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);
    logic [63:0] r_quo;
    logic [64:0] r_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] n_shift;
    logic [64:0] n_sub;

    always_comb begin
        n_shift = {r_rem[63:0], r_quo[63]};
        n_sub   = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!n_sub[64]) begin
                    r_rem <= n_sub;
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[63:0];
endmodule

### design/crt_congruence_combiner.sv
// Congruence combiner: folds a stream of congruences x = residue mod modulus
// (moduli need not be coprime) into one running congruence.
// Input channel (crt_in_if, sink): residue, modulus, last. A transfer takes
// place when valid and ready are high at a rising edge of i_clk.
// Output channel (crt_out_if, source): result_residue, result_modulus and
// status (0 solved, 1 no solution, 2 overflow); one transfer per item
// marked last, residue and modulus zero on error.
// Arithmetic: every division runs on one shared 64-step restoring divider and
// every multiply on a shift-add multiplier. A fold with m/g above 1 costs
// a dozen fixed divisions, one division per gcd step, one division plus one
// multiply per inverse step and three multiplies. An item that meets a held
// error or a zero modulus skips the arithmetic. One item at a time; ready is
// low while an item is in work.
// Reset (synchronous, i_rst_n low) clears the running state to 0 mod 1,
// status ok, and drops any pending result.
// When the receiver stalls, the result sits in the output register and the
// next item may still be taken and worked on; it waits only if it too
// must deliver a result before the register is free.
module crt_congruence_combiner #(
    parameter int MOD_WIDTH = 32,
    parameter int ACC_WIDTH = 63
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    crt_in_if.sink  i_in,
    crt_out_if.source o_out
);
    typedef enum logic [20:0] {
        S_IDLE  = 21'd1,
        S_RED   = 21'd2,    // r2 = r2 % m
        S_GCD   = 21'd4,    // Euclid a % b
        S_CHK1  = 21'd8,    // r2 % g
        S_CHK2  = 21'd16,   // res % g
        S_MG    = 21'd32,   // m / g
        S_OVF   = 21'd64,   // maxv / mg
        S_RM    = 21'd128,  // res % m
        S_BG    = 21'd256,  // big / g
        S_BGM   = 21'd512,  // (big/g) % mg
        S_DG    = 21'd1024, // diff / g
        S_DGM   = 21'd2048, // % mg
        S_INV   = 21'd4096, // ext Euclid r0 / r1
        S_INV2  = 21'd8192, // s update multiply
        S_INVF  = 21'd16384,// final s % n
        S_MUL   = 21'd32768,// shift-add multiply
        S_MULR  = 21'd65536,// product % mg
        S_MUL2  = 21'd131072,// big * p and big * mg
        S_FOLD  = 21'd262144,
        S_EMIT  = 21'd524288,
        S_WAIT  = 21'd1048576
    } t_state;

    // multiply purpose, selects where the multiplier hands back
    typedef enum logic [1:0] {
        M_QS   = 2'd0,  // q * s1
        M_PROD = 2'd1,  // diff * inverse
        M_BIGP = 2'd2,  // big * p
        M_BIGM = 2'd3   // big * mg
    } t_mul_mode;

    localparam logic [63:0] MAXV = (64'd1 << ACC_WIDTH) - 64'd1;
    localparam logic [63:0] WMASK = (64'd1 << MOD_WIDTH) - 64'd1;

    t_state r_state;
    logic [63:0] r_res, r_big, r_r2, r_m, r_g, r_a, r_b, r_mg, r_diff;
    logic [63:0] r_r0, r_r1;
    logic signed [64:0] r_s0, r_s1;
    logic [63:0] r_x, r_y, r_v;
    logic [127:0] r_acc;
    logic [6:0] r_mcnt;
    t_mul_mode r_mode;
    logic [1:0] r_st;
    logic r_last, r_dstart, r_ovalid;
    logic [62:0] r_ores, r_omod;
    logic [1:0] r_ost;
    logic [63:0] r_dnum, r_dden;
    logic d_done;
    logic [63:0] d_quo, d_rem;
    logic [63:0] n_inv;

    crt_divider u_div (
        .i_clk, .i_rst_n, .i_start(r_dstart), .i_num(r_dnum), .i_den(r_dden),
        .o_done(d_done), .o_quo(d_quo), .o_rem(d_rem)
    );

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ovalid;
    assign o_out.result_residue = r_ores;
    assign o_out.result_modulus = r_omod;
    assign o_out.status        = r_ost;

    // final inverse value once s0 is reduced mod n (divider remainder sign fix)
    always_comb begin
        n_inv = r_s0[64] ? (r_mg - d_rem) : d_rem;
        if (n_inv == r_mg) n_inv = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_res    <= '0;
            r_big    <= 64'd1;
            r_st     <= crt_pkg::ST_OK;
            r_dstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_r2   <= {32'd0, i_in.residue} & WMASK;
                        r_m    <= {32'd0, i_in.modulus} & WMASK;
                        r_last <= i_in.last;
                        if (r_st != crt_pkg::ST_OK) begin
                            r_state <= S_EMIT;
                        end else if (({32'd0, i_in.modulus} & WMASK) == 64'd0) begin
                            r_st    <= crt_pkg::ST_NOSOL;
                            r_state <= S_EMIT;
                        end else begin
                            r_dnum   <= {32'd0, i_in.residue} & WMASK;
                            r_dden   <= {32'd0, i_in.modulus} & WMASK;
                            r_dstart <= 1'b1;
                            r_state  <= S_RED;
                        end
                    end
                end
                S_RED: if (d_done) begin
                    r_r2 <= d_rem;
                    r_a  <= r_big;
                    r_b  <= r_m;
                    r_dnum <= r_big; r_dden <= r_m; r_dstart <= 1'b1;
                    r_state <= S_GCD;
                end
                S_GCD: if (d_done) begin
                    if (d_rem == 64'd0) begin
                        r_g <= r_b;
                        r_dnum <= r_r2; r_dden <= r_b; r_dstart <= 1'b1;
                        r_state <= S_CHK1;
                    end else begin
                        r_a <= r_b; r_b <= d_rem;
                        r_dnum <= r_b; r_dden <= d_rem; r_dstart <= 1'b1;
                    end
                end
                S_CHK1: if (d_done) begin
                    r_v <= d_rem;
                    r_dnum <= r_res; r_dden <= r_g; r_dstart <= 1'b1;
                    r_state <= S_CHK2;
                end
                S_CHK2: if (d_done) begin
                    if (d_rem != r_v) begin
                        r_st <= crt_pkg::ST_NOSOL;
                        r_state <= S_EMIT;
                    end else begin
                        r_dnum <= r_m; r_dden <= r_g; r_dstart <= 1'b1;
                        r_state <= S_MG;
                    end
                end
                S_MG: if (d_done) begin
                    r_mg <= d_quo;
                    r_dnum <= MAXV; r_dden <= d_quo; r_dstart <= 1'b1;
                    r_state <= S_OVF;
                end
                S_OVF: if (d_done) begin
                    if (r_big > d_quo) begin
                        r_st <= crt_pkg::ST_OVF;
                        r_state <= S_EMIT;
                    end else begin
                        r_dnum <= r_res; r_dden <= r_m; r_dstart <= 1'b1;
                        r_state <= S_RM;
                    end
                end
                S_RM: if (d_done) begin
                    r_diff <= (r_r2 >= d_rem) ? (r_r2 - d_rem) : (r_r2 + r_m - d_rem);
                    if (r_mg == 64'd1) begin
                        r_v <= '0;
                        r_x <= r_big; r_y <= r_mg; r_mode <= M_BIGM;
                        r_acc <= '0; r_mcnt <= 7'd64;
                        r_state <= S_MUL;
                    end else begin
                        r_dnum <= r_big; r_dden <= r_g; r_dstart <= 1'b1;
                        r_state <= S_BG;
                    end
                end
                S_BG: if (d_done) begin
                    r_dnum <= d_quo; r_dden <= r_mg; r_dstart <= 1'b1;
                    r_state <= S_BGM;
                end
                S_BGM: if (d_done) begin
                    r_a <= d_rem;
                    r_dnum <= r_diff; r_dden <= r_g; r_dstart <= 1'b1;
                    r_state <= S_DG;
                end
                S_DG: if (d_done) begin
                    r_dnum <= d_quo; r_dden <= r_mg; r_dstart <= 1'b1;
                    r_state <= S_DGM;
                end
                S_DGM: if (d_done) begin
                    r_diff <= d_rem;
                    r_r0 <= r_a; r_r1 <= r_mg;
                    r_s0 <= 65'sd1; r_s1 <= 65'sd0;
                    r_dnum <= r_a; r_dden <= r_mg; r_dstart <= 1'b1;
                    r_state <= S_INV;
                end
                S_INV: if (d_done) begin
                    r_r0 <= r_r1; r_r1 <= d_rem;
                    r_x <= d_quo;
                    r_y <= r_s1[64] ? (64'd0 - r_s1[63:0]) : r_s1[63:0];
                    r_acc <= '0; r_mcnt <= 7'd64; r_mode <= M_QS;
                    r_state <= S_MUL;
                end
                S_INV2: begin
                    r_s0 <= r_s1;
                    r_s1 <= r_s0 - (r_s1[64] ? -$signed({1'b0, r_acc[63:0]})
                                              : $signed({1'b0, r_acc[63:0]}));
                    if (r_r1 == 64'd0) begin
                        r_state <= S_INVF;
                        r_dnum <= r_s1[64] ? (64'd0 - r_s1[63:0]) : r_s1[63:0];
                        r_dden <= r_mg; r_dstart <= 1'b1;
                    end else begin
                        r_dnum <= r_r0; r_dden <= r_r1; r_dstart <= 1'b1;
                        r_state <= S_INV;
                    end
                end
                S_INVF: if (d_done) begin
                    r_x <= r_diff; r_y <= n_inv;
                    r_acc <= '0; r_mcnt <= 7'd64; r_mode <= M_PROD;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc <= (r_acc << 1) + (r_y[63] ? {64'd0, r_x} : 128'd0);
                    r_y <= r_y << 1;
                    r_mcnt <= r_mcnt - 7'd1;
                    if (r_mcnt == 7'd1) begin
                        unique case (r_mode)
                            M_QS:    r_state <= S_INV2;
                            M_PROD:  r_state <= S_MULR;
                            M_BIGP:  r_state <= S_MUL2;
                            default: r_state <= S_FOLD;
                        endcase
                    end
                end
                S_MULR: begin
                    r_dnum <= r_acc[63:0]; r_dden <= r_mg; r_dstart <= 1'b1;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    if (r_mode == M_PROD) begin
                        // waiting for p = product % mg
                        if (!r_dstart && d_done) begin
                            r_x <= r_big; r_y <= d_rem;
                            r_acc <= '0; r_mcnt <= 7'd64;
                            r_mode <= M_BIGP;
                            r_state <= S_MUL;
                        end
                    end else begin
                        // big * p done: new residue, then big * mg
                        r_res <= r_res + r_acc[63:0];
                        r_x <= r_big; r_y <= r_mg;
                        r_acc <= '0; r_mcnt <= 7'd64;
                        r_mode <= M_BIGM;
                        r_state <= S_MUL;
                    end
                end
                S_FOLD: begin
                    r_big <= r_acc[63:0];
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_ost <= r_st;
                        r_ores <= (r_st == crt_pkg::ST_OK) ? r_res[62:0] : 63'd0;
                        r_omod <= (r_st == crt_pkg::ST_OK) ? r_big[62:0] : 63'd0;
                        r_res <= '0; r_big <= 64'd1; r_st <= crt_pkg::ST_OK;
                        r_state <= S_IDLE;
                    end
                end
                S_WAIT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
